>>> rtl/mandelbrot_escape_time_unit_assert.svh
// Assertion macros used by the port checker.
`ifndef MANDELBROT_ESCAPE_TIME_UNIT_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define MET_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off while reset is asserted.
`define MET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds during reset.
`define MET_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/met_pkg.sv
`timescale 1ns / 1ps

package met_pkg;

    typedef logic [2:0] t_cfg_index;

    localparam t_cfg_index CFG_ORIGIN_RE    = 3'd0;
    localparam t_cfg_index CFG_ORIGIN_IM    = 3'd1;
    localparam t_cfg_index CFG_STEP_RE      = 3'd2;
    localparam t_cfg_index CFG_STEP_IM      = 3'd3;
    localparam t_cfg_index CFG_MAX_ITER     = 3'd4;
    localparam t_cfg_index CFG_IMAGE_WIDTH  = 3'd5;
    localparam t_cfg_index CFG_IMAGE_HEIGHT = 3'd6;

    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_UPD,
        BK_DONE
    } t_back_state;

endpackage

>>> rtl/met_front.sv
`timescale 1ns / 1ps

module met_front #(
    parameter int COORD_BITS = 32,
    parameter int MAX_DIM    = 1024,
    parameter int DIM_BITS   = 10,
    parameter int SIZE_BITS  = 11
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [DIM_BITS-1:0]          i_column,
    input  logic [DIM_BITS-1:0]          i_row,
    input  logic signed [COORD_BITS-1:0] i_origin_re,
    input  logic signed [COORD_BITS-1:0] i_origin_im,
    input  logic signed [COORD_BITS-1:0] i_step_re,
    input  logic signed [COORD_BITS-1:0] i_step_im,
    input  logic [SIZE_BITS-1:0]         i_image_width,
    input  logic [SIZE_BITS-1:0]         i_image_height,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [DIM_BITS-1:0]          o_column,
    output logic [DIM_BITS-1:0]          o_row,
    output logic                         o_out_of_range,
    output logic signed [COORD_BITS-1:0] o_c_re,
    output logic signed [COORD_BITS-1:0] o_c_im
);

    localparam int P_BITS = COORD_BITS + DIM_BITS + 1;
    localparam int S_BITS = P_BITS + 1;
    localparam logic [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic                     r_valid;
    logic [DIM_BITS-1:0]      r_column;
    logic [DIM_BITS-1:0]      r_row;
    logic                     r_oor;
    logic signed [P_BITS-1:0] r_prod_re;
    logic signed [P_BITS-1:0] r_prod_im;

    logic                     accept;
    logic                     n_oor;
    logic signed [P_BITS-1:0] n_prod_re;
    logic signed [P_BITS-1:0] n_prod_im;
    logic signed [S_BITS-1:0] sum_re;
    logic signed [S_BITS-1:0] sum_im;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_oor = ({1'b0, i_column} >= i_image_width) || ({1'b0, i_row} >= i_image_height) ||
                ({1'b0, i_column} >= SIZE_BITS'(MAX_DIM)) ||
                ({1'b0, i_row} >= SIZE_BITS'(MAX_DIM));
        n_prod_re = P_BITS'(i_step_re) * P_BITS'($signed({1'b0, i_column}));
        n_prod_im = P_BITS'(i_step_im) * P_BITS'($signed({1'b0, i_row}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_column  <= i_column;
            r_row     <= i_row;
            r_oor     <= n_oor;
            r_prod_re <= n_prod_re;
            r_prod_im <= n_prod_im;
        end
    end

    // c = origin + step * index, saturated
    always_comb begin
        sum_re = S_BITS'(i_origin_re) + S_BITS'(r_prod_re);
        sum_im = S_BITS'(i_origin_im) + S_BITS'(r_prod_im);
        if (sum_re[S_BITS-1:COORD_BITS-1] == {(S_BITS-COORD_BITS+1){sum_re[COORD_BITS-1]}}) begin
            o_c_re = sum_re[COORD_BITS-1:0];
        end else begin
            o_c_re = sum_re[S_BITS-1] ? C_MIN : C_MAX;
        end
        if (sum_im[S_BITS-1:COORD_BITS-1] == {(S_BITS-COORD_BITS+1){sum_im[COORD_BITS-1]}}) begin
            o_c_im = sum_im[COORD_BITS-1:0];
        end else begin
            o_c_im = sum_im[S_BITS-1] ? C_MIN : C_MAX;
        end
    end

    assign o_valid        = r_valid;
    assign o_column       = r_column;
    assign o_row          = r_row;
    assign o_out_of_range = r_oor;

endmodule

>>> rtl/met_fifo.sv
`timescale 1ns / 1ps

module met_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;

    logic                push;
    logic                pop;
    logic [PTR_BITS-1:0] n_wr_ptr;
    logic [PTR_BITS-1:0] n_rd_ptr;
    logic [CNT_BITS-1:0] n_count;

    assign o_ready = (r_count != CNT_BITS'(DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        unique case ({push, pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> rtl/met_back.sv
`timescale 1ns / 1ps

module met_back
    import met_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 28,
    parameter int COUNT_BITS = 16,
    parameter int DIM_BITS   = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [DIM_BITS-1:0]          i_column,
    input  logic [DIM_BITS-1:0]          i_row,
    input  logic                         i_out_of_range,
    input  logic signed [COORD_BITS-1:0] i_c_re,
    input  logic signed [COORD_BITS-1:0] i_c_im,
    input  logic [COUNT_BITS-1:0]        i_max_iter,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [DIM_BITS-1:0]          o_column,
    output logic [DIM_BITS-1:0]          o_row,
    output logic [COUNT_BITS-1:0]        o_iteration_count,
    output logic                         o_stayed_bounded,
    output logic                         o_out_of_range
);

    localparam int C  = COORD_BITS;
    localparam int W2 = 2 * COORD_BITS;
    localparam logic [C-1:0] C_MAX = {1'b0, {(C-1){1'b1}}};
    localparam logic [C-1:0] C_MIN = {1'b1, {(C-1){1'b0}}};
    localparam logic signed [C+1:0] FOUR = $signed((C+2)'(1) << (FRAC_BITS + 2));

    t_back_state r_state;
    t_back_state n_state;

    logic [DIM_BITS-1:0]   r_column;
    logic [DIM_BITS-1:0]   r_row;
    logic                  r_oor;
    logic signed [C-1:0]   r_cre;
    logic signed [C-1:0]   r_cim;
    logic signed [C-1:0]   r_x;
    logic signed [C-1:0]   r_y;
    logic [COUNT_BITS-1:0] r_count;
    logic signed [W2-1:0]  r_xx;
    logic signed [W2-1:0]  r_yy;
    logic signed [W2-1:0]  r_xy;

    logic                  load;
    logic                  mul;
    logic                  update;
    logic signed [W2-1:0]  xx_sh;
    logic signed [W2-1:0]  yy_sh;
    logic signed [W2-1:0]  xy_sh;
    logic signed [C-1:0]   x2;
    logic signed [C-1:0]   y2;
    logic signed [C-1:0]   xy2;
    logic signed [C+1:0]   mag;
    logic                  escape;
    logic signed [C+1:0]   x_wide;
    logic signed [C:0]     y_wide;
    logic signed [C-1:0]   n_x;
    logic signed [C-1:0]   n_y;
    logic [COUNT_BITS-1:0] n_count;

    // truncate products toward minus infinity, saturate, test and step
    always_comb begin
        xx_sh = r_xx >>> FRAC_BITS;
        yy_sh = r_yy >>> FRAC_BITS;
        xy_sh = r_xy >>> (FRAC_BITS - 1);
        if (xx_sh[W2-1:C-1] == {(W2-C+1){xx_sh[C-1]}}) begin
            x2 = xx_sh[C-1:0];
        end else begin
            x2 = xx_sh[W2-1] ? C_MIN : C_MAX;
        end
        if (yy_sh[W2-1:C-1] == {(W2-C+1){yy_sh[C-1]}}) begin
            y2 = yy_sh[C-1:0];
        end else begin
            y2 = yy_sh[W2-1] ? C_MIN : C_MAX;
        end
        if (xy_sh[W2-1:C-1] == {(W2-C+1){xy_sh[C-1]}}) begin
            xy2 = xy_sh[C-1:0];
        end else begin
            xy2 = xy_sh[W2-1] ? C_MIN : C_MAX;
        end
        mag    = (C+2)'(x2) + (C+2)'(y2);
        escape = (mag >= FOUR);
        x_wide = (C+2)'(x2) - (C+2)'(y2) + (C+2)'(r_cre);
        y_wide = (C+1)'(xy2) + (C+1)'(r_cim);
        if (x_wide[C+1:C-1] == {3{x_wide[C-1]}}) begin
            n_x = x_wide[C-1:0];
        end else begin
            n_x = x_wide[C+1] ? C_MIN : C_MAX;
        end
        if (y_wide[C:C-1] == {2{y_wide[C-1]}}) begin
            n_y = y_wide[C-1:0];
        end else begin
            n_y = y_wide[C] ? C_MIN : C_MAX;
        end
        n_count = r_count + COUNT_BITS'(1);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_valid) begin
                    if (i_out_of_range || (i_max_iter == '0)) begin
                        n_state = BK_DONE;
                    end else begin
                        n_state = BK_MUL;
                    end
                end
            end
            BK_MUL: begin
                n_state = BK_UPD;
            end
            BK_UPD: begin
                if (escape || (n_count == i_max_iter)) begin
                    n_state = BK_DONE;
                end else begin
                    n_state = BK_MUL;
                end
            end
            BK_DONE: begin
                if (i_ready) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == BK_IDLE);
        o_valid = (r_state == BK_DONE);
        load    = (r_state == BK_IDLE) && i_valid;
        mul     = (r_state == BK_MUL);
        update  = (r_state == BK_UPD) && !escape;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_column <= i_column;
            r_row    <= i_row;
            r_oor    <= i_out_of_range;
            r_cre    <= i_c_re;
            r_cim    <= i_c_im;
            r_x      <= '0;
            r_y      <= '0;
            r_count  <= '0;
        end else if (update) begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_count <= n_count;
        end
        if (mul) begin
            r_xx <= W2'(r_x) * W2'(r_x);
            r_yy <= W2'(r_y) * W2'(r_y);
            r_xy <= W2'(r_x) * W2'(r_y);
        end
    end

    assign o_column          = r_column;
    assign o_row             = r_row;
    assign o_iteration_count = r_count;
    assign o_out_of_range    = r_oor;
    assign o_stayed_bounded  = !r_oor && (r_count == i_max_iter);

endmodule

>>> rtl/mandelbrot_escape_time_unit.sv
`timescale 1ns / 1ps

// Mandelbrot escape-time unit. Each input transfer names one pixel; the front end maps it
// to c = origin + step * (column, row) through one register stage and queues it, the back
// end iterates z = z*z + c and returns one result transfer per pixel, in order. An iteration
// has a multiply state (three parallel multiplies) and an update state (truncate, escape
// test and update); an out-of-range pixel or a zero limit skips the iteration loop. The
// iteration loop sets the rate; the two-entry queue lets new pixels be taken while a result
// waits. Configuration writes are always accepted.
module mandelbrot_escape_time_unit
    import met_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 28,
    parameter int MAX_DIM    = 1024,
    parameter int COUNT_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [$clog2(MAX_DIM)-1:0]         i_column,
    input  logic [$clog2(MAX_DIM)-1:0]         i_row,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [$clog2(MAX_DIM)-1:0]         o_out_column,
    output logic [$clog2(MAX_DIM)-1:0]         o_out_row,
    output logic [COUNT_BITS-1:0]              o_iteration_count,
    output logic                               o_stayed_bounded,
    output logic                               o_out_of_range,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]          i_cfg_index,
    input  logic [((COORD_BITS > COUNT_BITS ? COORD_BITS : COUNT_BITS) >
                   ($clog2(MAX_DIM) + 1) ?
                   (COORD_BITS > COUNT_BITS ? COORD_BITS : COUNT_BITS) :
                   ($clog2(MAX_DIM) + 1))-1:0] i_cfg_data
);

    localparam int DIM_BITS    = $clog2(MAX_DIM);
    localparam int SIZE_BITS   = DIM_BITS + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_WIDTH     = 2 * DIM_BITS + 1 + 2 * COORD_BITS;

    logic signed [COORD_BITS-1:0] r_origin_re;
    logic signed [COORD_BITS-1:0] r_origin_im;
    logic signed [COORD_BITS-1:0] r_step_re;
    logic signed [COORD_BITS-1:0] r_step_im;
    logic [COUNT_BITS-1:0]        r_max_iter;
    logic [SIZE_BITS-1:0]         r_image_width;
    logic [SIZE_BITS-1:0]         r_image_height;

    logic                         fr_valid;
    logic                         fr_ready;
    logic [DIM_BITS-1:0]          fr_column;
    logic [DIM_BITS-1:0]          fr_row;
    logic                         fr_oor;
    logic signed [COORD_BITS-1:0] fr_c_re;
    logic signed [COORD_BITS-1:0] fr_c_im;

    logic                         q_valid;
    logic                         q_ready;
    logic [Q_WIDTH-1:0]           q_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_re    <= '0;
            r_origin_im    <= '0;
            r_step_re      <= '0;
            r_step_im      <= '0;
            r_max_iter     <= COUNT_BITS'(256);
            r_image_width  <= SIZE_BITS'(MAX_DIM);
            r_image_height <= SIZE_BITS'(MAX_DIM);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_RE:    r_origin_re    <= i_cfg_data[COORD_BITS-1:0];
                CFG_ORIGIN_IM:    r_origin_im    <= i_cfg_data[COORD_BITS-1:0];
                CFG_STEP_RE:      r_step_re      <= i_cfg_data[COORD_BITS-1:0];
                CFG_STEP_IM:      r_step_im      <= i_cfg_data[COORD_BITS-1:0];
                CFG_MAX_ITER:     r_max_iter     <= i_cfg_data[COUNT_BITS-1:0];
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[SIZE_BITS-1:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[SIZE_BITS-1:0];
                default: ;
            endcase
        end
    end

    met_front #(
        .COORD_BITS (COORD_BITS),
        .MAX_DIM    (MAX_DIM),
        .DIM_BITS   (DIM_BITS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_column       (i_column),
        .i_row          (i_row),
        .i_origin_re    (r_origin_re),
        .i_origin_im    (r_origin_im),
        .i_step_re      (r_step_re),
        .i_step_im      (r_step_im),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .o_valid        (fr_valid),
        .i_ready        (fr_ready),
        .o_column       (fr_column),
        .o_row          (fr_row),
        .o_out_of_range (fr_oor),
        .o_c_re         (fr_c_re),
        .o_c_im         (fr_c_im)
    );

    met_fifo #(
        .WIDTH (Q_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_data  ({fr_column, fr_row, fr_oor, fr_c_re, fr_c_im}),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    met_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .COUNT_BITS (COUNT_BITS),
        .DIM_BITS   (DIM_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (q_valid),
        .o_ready           (q_ready),
        .i_column          (q_data[Q_WIDTH-1 -: DIM_BITS]),
        .i_row             (q_data[Q_WIDTH-DIM_BITS-1 -: DIM_BITS]),
        .i_out_of_range    (q_data[2*COORD_BITS]),
        .i_c_re            (q_data[2*COORD_BITS-1 -: COORD_BITS]),
        .i_c_im            (q_data[COORD_BITS-1:0]),
        .i_max_iter        (r_max_iter),
        .o_valid           (o_out_valid),
        .i_ready           (i_out_ready),
        .o_column          (o_out_column),
        .o_row             (o_out_row),
        .o_iteration_count (o_iteration_count),
        .o_stayed_bounded  (o_stayed_bounded),
        .o_out_of_range    (o_out_of_range)
    );

endmodule

>>> rtl/met_port_checker.sv
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_unit_assert.svh"

module met_port_checker #(
    parameter int MAX_DIM    = 1024,
    parameter int COUNT_BITS = 16
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [$clog2(MAX_DIM)-1:0] o_out_column,
    input logic [$clog2(MAX_DIM)-1:0] o_out_row,
    input logic [COUNT_BITS-1:0]      o_iteration_count,
    input logic                       o_stayed_bounded,
    input logic                       o_out_of_range
);

    `MET_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `MET_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_iteration_count) && $stable(o_out_column) && $stable(o_out_row))
    `MET_ASSERT_NOW(a_oor_result, i_clk, i_rst_n, o_out_valid && o_out_of_range, (o_iteration_count == '0) && !o_stayed_bounded)
    `MET_ASSERT_ALWAYS_NEXT(a_reset_idle, i_clk, !i_rst_n, !o_out_valid)

endmodule

bind mandelbrot_escape_time_unit met_port_checker #(
    .MAX_DIM    (MAX_DIM),
    .COUNT_BITS (COUNT_BITS)
) u_met_port_checker (.*);

>>> bench/testbench.sv
`timescale 1ns / 1ps

localparam int      Q_FRAC         = 28;
localparam int      ONE            = 1 << Q_FRAC;
localparam int      COORD_MAX      = 32'sh7FFF_FFFF;
localparam int      COORD_MIN      = 32'sh8000_0000;
localparam longint  ESCAPE_LIMIT   = longint'(4) <<< Q_FRAC;

typedef struct {
    int unsigned column;
    int unsigned row;
    int unsigned count;
    bit          bounded;
    bit          outside;
} t_pixel_result;

class pixel_scoreboard;
    int           origin_re;
    int           origin_im;
    int           step_re;
    int           step_im;
    int unsigned  max_iter;
    int unsigned  image_width;
    int unsigned  image_height;
    t_pixel_result expected_pixels[$];
    int           errors;
    int           checked;
    int           bounded_seen;
    int           escaped_seen;
    int           outside_seen;

    function new();
        origin_re    = 0;
        origin_im    = 0;
        step_re      = 0;
        step_im      = 0;
        max_iter     = 256;
        image_width  = 1024;
        image_height = 1024;
        errors       = 0;
        checked      = 0;
        bounded_seen = 0;
        escaped_seen = 0;
        outside_seen = 0;
    endfunction

    function void write_reg(met_pkg::t_cfg_index idx, logic [31:0] data);
        case (idx)
            met_pkg::CFG_ORIGIN_RE:    origin_re    = int'(data);
            met_pkg::CFG_ORIGIN_IM:    origin_im    = int'(data);
            met_pkg::CFG_STEP_RE:      step_re      = int'(data);
            met_pkg::CFG_STEP_IM:      step_im      = int'(data);
            met_pkg::CFG_MAX_ITER:     max_iter     = 32'(data[15:0]);
            met_pkg::CFG_IMAGE_WIDTH:  image_width  = 32'(data[10:0]);
            met_pkg::CFG_IMAGE_HEIGHT: image_height = 32'(data[10:0]);
            default: ;
        endcase
    endfunction

    function longint clamp_coord(longint v);
        if (v > longint'(COORD_MAX)) return longint'(COORD_MAX);
        if (v < longint'(COORD_MIN)) return longint'(COORD_MIN);
        return v;
    endfunction

    // exact product, floor shift, saturate
    function longint fixed_mul(longint a, longint b, int sh);
        return clamp_coord((a * b) >>> sh);
    endfunction

    function t_pixel_result escape_time(int unsigned col, int unsigned row);
        t_pixel_result r;
        longint cre, cim, x, y, x2, y2, xy2;
        int unsigned n;
        r.column  = col;
        r.row     = row;
        r.outside = (col >= image_width) || (row >= image_height);
        n = 0;
        if (!r.outside) begin
            cre = clamp_coord(longint'(origin_re) + longint'(step_re) * longint'(col));
            cim = clamp_coord(longint'(origin_im) + longint'(step_im) * longint'(row));
            x = 0;
            y = 0;
            while (n < max_iter) begin
                x2 = fixed_mul(x, x, Q_FRAC);
                y2 = fixed_mul(y, y, Q_FRAC);
                if (x2 + y2 >= ESCAPE_LIMIT) break;
                xy2 = fixed_mul(x, y, Q_FRAC - 1);
                x = clamp_coord(x2 - y2 + cre);
                y = clamp_coord(xy2 + cim);
                n++;
            end
        end
        r.count   = n;
        r.bounded = !r.outside && (n == max_iter);
        return r;
    endfunction

    function void note_pixel(int unsigned col, int unsigned row);
        expected_pixels.push_back(escape_time(col, row));
    endfunction

    function int pending();
        return expected_pixels.size();
    endfunction

    function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val,
                     act_val);
            errors++;
        end
    endfunction

    function void check_result(int unsigned col, int unsigned row, int unsigned count,
                               bit bounded, bit outside);
        t_pixel_result e;
        if (expected_pixels.size() == 0) begin
            $display("%0t: result for pixel (%0d,%0d) with no pixel pending", $time, col, row);
            errors++;
            return;
        end
        e = expected_pixels.pop_front();
        compare_field("out_column", e.column, col);
        compare_field("out_row", e.row, row);
        compare_field("iteration_count", e.count, count);
        compare_field("stayed_bounded", e.bounded, bounded);
        compare_field("out_of_range", e.outside, outside);
        checked++;
        if (e.outside) outside_seen++;
        else if (e.bounded) bounded_seen++;
        else escaped_seen++;
    endfunction
endclass

module testbench;
    import met_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RANDOM_PIXELS  = 1500;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 400000;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [9:0]         i_column;
    logic [9:0]         i_row;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [9:0]         o_out_column;
    logic [9:0]         o_out_row;
    logic [15:0]        o_iteration_count;
    logic               o_stayed_bounded;
    logic               o_out_of_range;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    t_cfg_index         i_cfg_index;
    logic [31:0]        i_cfg_data;

    pixel_scoreboard    sb;
    bit                 quiet;
    bit                 hold_request;
    bit                 hold_taken;
    int                 settings_applied;
    int                 stalled_cycles = 0;

    mandelbrot_escape_time_unit u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_column          (i_column),
        .i_row             (i_row),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_column      (o_out_column),
        .o_out_row         (o_out_row),
        .o_iteration_count (o_iteration_count),
        .o_stayed_bounded  (o_stayed_bounded),
        .o_out_of_range    (o_out_of_range),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic int idle_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_dim();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 1;
        if (r == 1) return 1024;
        if (r < 6) return $urandom_range(2, 64);
        return $urandom_range(65, 1024);
    endfunction

    task automatic send_pixel(input int col, input int row);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_column   <= 10'(col);
        i_row      <= 10'(row);
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_pixel(col, row);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_view(input int ore, input int oim, input int sre, input int sim,
                              input int iter, input int w, input int h);
        write_reg(CFG_ORIGIN_RE, ore);
        write_reg(CFG_ORIGIN_IM, oim);
        write_reg(CFG_STEP_RE, sre);
        write_reg(CFG_STEP_IM, sim);
        write_reg(CFG_MAX_ITER, iter);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        i_cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    task automatic wait_results();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic random_view(output int items, output int w, output int h);
        int ore, oim, sre, sim, iter, r;
        w = pick_dim();
        h = pick_dim();
        if ($urandom_range(0, 3) == 0) begin
            ore = $urandom;
            oim = $urandom;
            sre = $urandom;
            sim = $urandom;
        end else begin
            ore = int'($urandom_range(0, 3 * ONE)) - 5 * ONE / 2;
            oim = int'($urandom_range(0, 2 * ONE)) - 3 * ONE / 2;
            sre = int'($urandom_range(ONE / 64, 4 * ONE)) / w;
            sim = int'($urandom_range(ONE / 64, 3 * ONE)) / h;
            if ($urandom_range(0, 1)) sre = -sre;
            if ($urandom_range(0, 1)) sim = -sim;
        end
        r = $urandom_range(0, 99);
        items = $urandom_range(60, 140);
        if (r < 4) begin
            iter = 0;
        end else if (r < 8) begin
            iter = 1;
        end else if (r < 70) begin
            iter = $urandom_range(2, 48);
        end else if (r < 92) begin
            iter = $urandom_range(49, 300);
        end else begin
            iter = $urandom_range(1000, 3000);
            items = 20;
        end
        apply_view(ore, oim, sre, sim, iter, w, h);
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin : result_sink
        int n;
        i_out_ready = 1'b0;
        hold_taken  = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                n = idle_gap();
                i_out_ready <= (n == 0);
                repeat ((n == 0) ? 1 : n) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_out_column, o_out_row, o_iteration_count, o_stayed_bounded,
                            o_out_of_range);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                stalled_cycles <= 0;
            else
                stalled_cycles <= stalled_cycles + 1;
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, stalled_cycles);
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int sent, phase, items, w, h, col, row;
        sb               = new();
        quiet            = 1'b0;
        hold_request     = 1'b0;
        settings_applied = 0;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_column         = '0;
        i_row            = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = CFG_ORIGIN_RE;
        i_cfg_data       = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // values after reset: c = 0, bounded at 256
        send_pixel(0, 0);
        send_pixel(1023, 1023);
        wait_results();

        apply_view(-2 * ONE, -ONE - ONE / 2, 3 * ONE / 63, 3 * ONE / 47, 32, 64, 48);
        send_pixel(0, 0);
        send_pixel(63, 47);
        send_pixel(32, 24);
        send_pixel(40, 20);
        send_pixel(64, 0);
        send_pixel(0, 48);
        send_pixel(1023, 1023);
        wait_results();

        // zero limit, single-pixel image
        apply_view(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0, 1, 1);
        send_pixel(0, 0);
        send_pixel(1, 0);
        send_pixel(0, 1);
        wait_results();

        // saturation of c and z
        apply_view(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 5, 1024, 1024);
        send_pixel(1023, 1023);
        send_pixel(0, 0);
        send_pixel(512, 3);
        wait_results();

        // zero width
        apply_view(0, 0, 0, 0, 65535, 0, 1024);
        send_pixel(0, 0);
        send_pixel(5, 5);
        wait_results();

        // c = 2: leaves the disc on the step after the limit
        apply_view(2 * ONE, 0, 0, 0, 1, 4, 4);
        send_pixel(0, 0);
        wait_results();

        // full limit with a bounded point, then a fast escape
        apply_view(-ONE / 4, 0, 3 * ONE, 3 * ONE, 65535, 2, 2);
        send_pixel(0, 0);
        send_pixel(1, 1);
        wait_results();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_PIXELS) begin
            quiet = (phase % 5 == 3);
            random_view(items, w, h);
            if (phase == 0) hold_request = 1'b1;
            for (int k = 0; k < items; k++) begin
                if ($urandom_range(0, 99) < 85) begin
                    col = $urandom_range(0, w - 1);
                    row = $urandom_range(0, h - 1);
                end else begin
                    col = $urandom_range(0, 1023);
                    row = $urandom_range(0, 1023);
                end
                send_pixel(col, row);
                sent++;
            end
            wait_results();
            phase++;
        end

        repeat (16) @(posedge i_clk);
        $display("coverage: %0d pixels checked: %0d bounded, %0d escaped, %0d out of range",
                 sb.checked, sb.bounded_seen, sb.escaped_seen, sb.outside_seen);
        $display("coverage: %0d register settings incl. saturating views and zero limit",
                 settings_applied);
        if (sb.errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/met_pkg.sv
rtl/met_front.sv
rtl/met_fifo.sv
rtl/met_back.sv
rtl/mandelbrot_escape_time_unit.sv
rtl/met_port_checker.sv
bench/testbench.sv
